// ===== sv/sorted_key_node_table_core_defines.svh =====
// assertion macros for the table core rtl
`ifndef SORTED_KEY_NODE_TABLE_CORE_DEFINES_SVH
`define SORTED_KEY_NODE_TABLE_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// clocked check, suspended while reset is held
`define SKTBL_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked check that also holds during reset
`define SKTBL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define SKTBL_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define SKTBL_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== sv/sktbl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sktbl_pkg;

    // fixed field widths
    localparam int REQ_W    = 2;
    localparam int KEY_IN_W = 32;
    localparam int PAGE_W   = 24;
    localparam int SLOT_W   = 16;
    localparam int STATUS_W = 3;
    localparam int TOTAL_W  = 7;

    // packed stream widths
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 48;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_EXACT  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CHILD  = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FOUND     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_MISS      = 3'd4;

    // outcome of one key compare
    typedef struct packed {
        logic go_right;
        logic equal;
    } cmp_res_t;

endpackage

`default_nettype wire

// ===== sv/sktbl_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sktbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/sktbl_cmp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sktbl_cmp #(
    parameter int KEY_BITS = 32
) (
    input  wire logic [KEY_BITS-1:0] entry_key,
    input  wire logic [KEY_BITS-1:0] target_key,
    input  wire logic                strict,
    output sktbl_pkg::cmp_res_t      res
);

    import sktbl_pkg::*;

    logic is_lt;
    logic is_eq;

    // unsigned compare shared by every search step
    assign is_lt = entry_key < target_key;
    assign is_eq = entry_key == target_key;

    // lower bound moves right on less, upper bound also on equal
    assign res.go_right = is_lt | (strict & is_eq);
    assign res.equal    = is_eq;

endmodule

`default_nettype wire

// ===== sv/sorted_key_node_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// sorted key node table: one tree node held as an ascending table of unique
// keys, each with a record id (page, slot), in a single-port-read ram.
// input stream s_axis: tuser carries the request kind (insert, exact lookup,
// child lookup); tdata carries key, page and slot. output stream m_axis gives
// one result per request: tuser the status, tdata page, slot and entry total.
// one request is worked at a time; s_axis_tready is high only while idle.
// the request is taken in idle; then each binary search step reads the middle
// entry from ram and compares it in the shared comparator, and a last search
// state closes the search. an exact lookup then loads the output register; a
// child lookup first reads the floor entry; an insert that goes in first moves
// the entries from its position on up by one and then places the pair.
// reset clears the entry count and the result valid and returns to idle; ram
// contents are not cleared, as only entries below the count are ever read.
// a stalled receiver holds the result in the output register; a finished
// request then waits in its last state and no new request is taken.
`include "sorted_key_node_table_core_defines.svh"

module sorted_key_node_table_core #(
    parameter int CAPACITY = 64,
    parameter int KEY_BITS = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // key [31:0], rid_page [55:32], rid_slot [71:56]
    input  wire logic [sktbl_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // req_type [1:0]
    input  wire logic [sktbl_pkg::REQ_W-1:0]     s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // out_page [23:0], out_slot [39:24], entry_total [46:40], zero [47]
    output logic      [sktbl_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // status [2:0]
    output logic      [sktbl_pkg::STATUS_W-1:0]  m_axis_tuser
);

    import sktbl_pkg::*;

    localparam int AW    = $clog2(CAPACITY);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int ENT_W = KEY_BITS + PAGE_W + SLOT_W;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SEARCH = 3'd1;
    localparam logic [2:0] ST_CMP    = 3'd2;
    localparam logic [2:0] ST_PREV   = 3'd3;
    localparam logic [2:0] ST_SHIFT  = 3'd4;
    localparam logic [2:0] ST_PLACE  = 3'd5;
    localparam logic [2:0] ST_FIN    = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       lo_reg, lo_next;
    logic [CW-1:0]       hi_reg, hi_next;
    logic [CW-1:0]       sh_reg, sh_next;
    logic [CW-1:0]       mid_reg, mid_next;
    logic                found_reg, found_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       pend_addr_reg, pend_addr_next;
    logic                m_valid_reg, m_valid_next;

    logic [REQ_W-1:0]    req_reg, req_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [PAGE_W-1:0]   res_page_reg, res_page_next;
    logic [SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [STATUS_W-1:0] m_status_reg, m_status_next;
    logic [PAGE_W-1:0]   m_page_reg, m_page_next;
    logic [SLOT_W-1:0]   m_slot_reg, m_slot_next;
    logic [TOTAL_W-1:0]  m_total_reg, m_total_next;

    logic                s_accept;
    logic                out_free;
    logic [KEY_BITS-1:0] key_in;
    logic [TOTAL_W-1:0]  count_total;
    logic [CW-1:0]       mid_calc;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [ENT_W-1:0]    wr_data;
    logic [ENT_W-1:0]    rd_data;
    logic [KEY_BITS-1:0] rd_key;
    logic [PAGE_W-1:0]   rd_page;
    logic [SLOT_W-1:0]   rd_slot;
    cmp_res_t            cmp_res;

    // key width follows the parameter
    generate
        if (KEY_BITS <= KEY_IN_W) begin : g_key_trunc
            assign key_in = s_axis_tdata[KEY_BITS-1:0];
        end else begin : g_key_ext
            assign key_in = {{(KEY_BITS - KEY_IN_W){1'b0}}, s_axis_tdata[KEY_IN_W-1:0]};
        end
        if (CW >= TOTAL_W) begin : g_total_trunc
            assign count_total = count_reg[TOTAL_W-1:0];
        end else begin : g_total_ext
            assign count_total = {{(TOTAL_W - CW){1'b0}}, count_reg};
        end
    endgenerate

    assign s_accept = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;
    assign mid_calc = lo_reg + ((hi_reg - lo_reg) >> 1);

    // ram entry: key high, page, slot low
    assign rd_key  = rd_data[ENT_W-1 -: KEY_BITS];
    assign rd_page = rd_data[SLOT_W +: PAGE_W];
    assign rd_slot = rd_data[SLOT_W-1:0];

    // pending shift write wins; the new pair goes in once shifting is done
    assign wr_en   = pend_reg || (state_reg == ST_PLACE);
    assign wr_addr = pend_reg ? pend_addr_reg : lo_reg[AW-1:0];
    assign wr_data = pend_reg ? rd_data : {key_reg, page_reg, slot_reg};

    sktbl_ram #(
        .WIDTH (ENT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sktbl_cmp #(
        .KEY_BITS (KEY_BITS)
    ) u_cmp (
        .entry_key  (rd_key),
        .target_key (key_reg),
        .strict     (req_reg == REQ_CHILD),
        .res        (cmp_res)
    );

    // sequencer
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        sh_next         = sh_reg;
        mid_next        = mid_reg;
        found_next      = found_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        m_valid_next    = m_valid_reg;
        req_next        = req_reg;
        key_next        = key_reg;
        page_next       = page_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        res_slot_next   = res_slot_reg;
        m_status_next   = m_status_reg;
        m_page_next     = m_page_reg;
        m_slot_next     = m_slot_reg;
        m_total_next    = m_total_reg;
        rd_addr         = mid_calc[AW-1:0];

        if (m_valid_reg && m_axis_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    req_next      = s_axis_tuser;
                    key_next      = key_in;
                    page_next     = s_axis_tdata[KEY_IN_W +: PAGE_W];
                    slot_next     = s_axis_tdata[KEY_IN_W + PAGE_W +: SLOT_W];
                    found_next    = 1'b0;
                    res_page_next = '0;
                    res_slot_next = '0;
                    lo_next       = '0;
                    hi_next       = count_reg;
                    unique case (s_axis_tuser)
                        REQ_INSERT, REQ_EXACT: begin
                            state_next = ST_SEARCH;
                        end
                        REQ_CHILD: begin
                            lo_next = CW'(1);
                            if (count_reg == '0) begin
                                res_status_next = STATUS_MISS;
                                state_next      = ST_FIN;
                            end else begin
                                state_next = ST_SEARCH;
                            end
                        end
                        default: begin
                            res_status_next = STATUS_MISS;
                            state_next      = ST_FIN;
                        end
                    endcase
                end
            end
            ST_SEARCH: begin
                if (lo_reg < hi_reg) begin
                    // issue the read of the middle entry
                    mid_next   = mid_calc;
                    state_next = ST_CMP;
                end else begin
                    unique case (req_reg)
                        REQ_INSERT: begin
                            if (found_reg) begin
                                res_status_next = STATUS_DUPLICATE;
                                state_next      = ST_FIN;
                            end else if (count_reg == CW'(CAPACITY)) begin
                                res_status_next = STATUS_FULL;
                                state_next      = ST_FIN;
                            end else begin
                                sh_next    = count_reg;
                                state_next = ST_SHIFT;
                            end
                        end
                        REQ_EXACT: begin
                            res_status_next = found_reg ? STATUS_FOUND : STATUS_MISS;
                            state_next      = ST_FIN;
                        end
                        default: begin
                            // floor child sits just before the bound
                            rd_addr    = AW'(lo_reg - CW'(1));
                            state_next = ST_PREV;
                        end
                    endcase
                end
            end
            ST_CMP: begin
                if (cmp_res.go_right) begin
                    lo_next = mid_reg + CW'(1);
                end else begin
                    hi_next = mid_reg;
                end
                // unique keys: an equal probe is the final position
                if (cmp_res.equal && (req_reg != REQ_CHILD)) begin
                    found_next = 1'b1;
                    // only an exact lookup reports the stored id
                    if (req_reg == REQ_EXACT) begin
                        res_page_next = rd_page;
                        res_slot_next = rd_slot;
                    end
                end
                state_next = ST_SEARCH;
            end
            ST_PREV: begin
                res_status_next = STATUS_FOUND;
                res_page_next   = rd_page;
                res_slot_next   = '0;
                state_next      = ST_FIN;
            end
            ST_SHIFT: begin
                // read entry sh-1 now, write it to sh next cycle
                if (sh_reg > lo_reg) begin
                    rd_addr        = AW'(sh_reg - CW'(1));
                    pend_next      = 1'b1;
                    pend_addr_next = sh_reg[AW-1:0];
                    sh_next        = sh_reg - CW'(1);
                end else begin
                    state_next = ST_PLACE;
                end
            end
            ST_PLACE: begin
                count_next      = count_reg + CW'(1);
                res_status_next = STATUS_INSERTED;
                state_next      = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_page_next   = res_page_reg;
                    m_slot_next   = res_slot_reg;
                    m_total_next  = count_total;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload and search registers
    always_ff @(posedge aclk) begin
        lo_reg         <= lo_next;
        hi_reg         <= hi_next;
        sh_reg         <= sh_next;
        mid_reg        <= mid_next;
        found_reg      <= found_next;
        pend_addr_reg  <= pend_addr_next;
        req_reg        <= req_next;
        key_reg        <= key_next;
        page_reg       <= page_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        res_slot_reg   <= res_slot_next;
        m_status_reg   <= m_status_next;
        m_page_reg     <= m_page_next;
        m_slot_reg     <= m_slot_next;
        m_total_reg    <= m_total_next;
    end

    // stream outputs
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = m_status_reg;
    assign m_axis_tdata  = {1'b0, m_total_reg, m_slot_reg, m_page_reg};

    // checks
    `SKTBL_ASSERT_RST(a_count_bound, aclk, aresetn, count_reg <= CW'(CAPACITY),
        "entry count above capacity")
    `SKTBL_ASSERT_RST(a_count_only_on_place, aclk, aresetn,
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == ST_PLACE),
        "entry count changed outside place")
    `SKTBL_ASSERT_RST(a_place_no_pending, aclk, aresetn,
        (state_reg == ST_PLACE) |-> !pend_reg, "shift write still pending at place")
    `SKTBL_ASSERT_RST(a_result_from_fin, aclk, aresetn,
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_FIN), "result raised outside finish")
    `SKTBL_ASSERT_RST(a_search_window, aclk, aresetn,
        (state_reg == ST_CMP) |-> ((mid_reg >= lo_reg) && (mid_reg < hi_reg)),
        "probe outside search window")

endmodule

`default_nettype wire

// ===== test/tb_sorted_key_node_table_core.sv =====
`timescale 1ns / 1ps

module tb_sorted_key_node_table_core;
    import sktbl_pkg::*;

    localparam int CAPACITY        = 64;
    localparam int RANDOM_REQUESTS = 1000;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int TAIL_CYCLES     = 120;

    // request kind the block has no meaning for, it must change nothing
    localparam logic [REQ_W-1:0] REQ_UNKNOWN = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   page;
        logic [SLOT_W-1:0]   slot;
        logic [TOTAL_W-1:0]  total;
    } node_result_t;

    // mirror of the node table and the queue of results it implies
    class node_table_scoreboard;
        logic [KEY_IN_W-1:0] key_tab  [CAPACITY];
        logic [PAGE_W-1:0]   page_tab [CAPACITY];
        logic [SLOT_W-1:0]   slot_tab [CAPACITY];
        int unsigned         held;
        node_result_t        awaiting [$];
        int unsigned         mismatches;
        int unsigned         results_seen;
        int unsigned         status_seen [5];

        function new();
            held         = 0;
            mismatches   = 0;
            results_seen = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // first index in [from, held) whose key is at or above k (above k when strict), else held
        function int unsigned first_not_below(int unsigned from, logic [KEY_IN_W-1:0] k,
                                              bit strict);
            int unsigned lo, hi, mid;
            lo = from;
            hi = held;
            while (lo < hi) begin
                mid = lo + (hi - lo) / 2;
                if (strict ? (key_tab[mid] <= k) : (key_tab[mid] < k)) begin
                    lo = mid + 1;
                end else begin
                    hi = mid;
                end
            end
            return lo;
        endfunction

        // apply one accepted request to the mirror and queue its result
        function void note_request(logic [REQ_W-1:0] req, logic [KEY_IN_W-1:0] k,
                                   logic [PAGE_W-1:0] pg, logic [SLOT_W-1:0] sl);
            node_result_t r;
            int unsigned  pos;
            int unsigned  idx;
            r = '0;
            r.status = STATUS_MISS;
            case (req)
                REQ_INSERT: begin
                    pos = first_not_below(0, k, 1'b0);
                    if (pos < held && key_tab[pos] == k) begin
                        r.status = STATUS_DUPLICATE;
                    end else if (held >= CAPACITY) begin
                        r.status = STATUS_FULL;
                    end else begin
                        // open a hole at pos by moving later entries up
                        for (idx = held; idx > pos; idx--) begin
                            key_tab[idx]  = key_tab[idx-1];
                            page_tab[idx] = page_tab[idx-1];
                            slot_tab[idx] = slot_tab[idx-1];
                        end
                        key_tab[pos]  = k;
                        page_tab[pos] = pg;
                        slot_tab[pos] = sl;
                        held++;
                        r.status = STATUS_INSERTED;
                    end
                end
                REQ_EXACT: begin
                    pos = first_not_below(0, k, 1'b0);
                    if (pos < held && key_tab[pos] == k) begin
                        r.status = STATUS_FOUND;
                        r.page   = page_tab[pos];
                        r.slot   = slot_tab[pos];
                    end
                end
                REQ_CHILD: begin
                    // floor child: entry just before the first key above k
                    if (held > 0) begin
                        pos = first_not_below(1, k, 1'b1);
                        r.status = STATUS_FOUND;
                        r.page   = page_tab[pos-1];
                    end
                end
                default: begin
                end
            endcase
            r.total = TOTAL_W'(held);
            status_seen[r.status]++;
            awaiting = {awaiting, r};
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        // compare one accepted result with the oldest queued one
        function void check_result(node_result_t got);
            node_result_t want;
            results_seen++;
            if (awaiting.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: expected none, got status %0d page %0h",
                         $time, got.status, got.page);
                return;
            end
            want = awaiting.pop_front();
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("out_page", 32'(want.page), 32'(got.page));
            compare_field("out_slot", 32'(want.slot), 32'(got.slot));
            compare_field("entry_total", 32'(want.total), 32'(got.total));
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata;
    logic [REQ_W-1:0]      s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    node_table_scoreboard  sb;
    int unsigned           sender_idle_pct;
    int unsigned           receiver_idle_pct;

    sorted_key_node_table_core #(
        .CAPACITY(CAPACITY),
        .KEY_BITS(KEY_IN_W)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // result side back-pressure
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // watch both channels at the rising edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_request(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[55:32],
                                s_axis_tdata[71:56]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result({m_axis_tuser, m_axis_tdata[23:0], m_axis_tdata[39:24],
                                 m_axis_tdata[46:40]});
            end
        end
    end

    // stop a hung run
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("%0t: nothing moved on either channel for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // present one request, starting and ending at a falling edge
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [KEY_IN_W-1:0] k,
                                input logic [PAGE_W-1:0] pg, input logic [SLOT_W-1:0] sl);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {sl, pg, k};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [KEY_IN_W-1:0] random_key();
        case ($urandom_range(7))
            0:       return KEY_IN_W'($urandom_range(15));
            1:       return 32'hFFFF_FFFF - KEY_IN_W'($urandom_range(15));
            default: return $urandom;
        endcase
    endfunction

    // a key already in the table, or any key while it is empty
    function automatic logic [KEY_IN_W-1:0] held_key();
        if (sb.held == 0) return random_key();
        return sb.key_tab[$urandom_range(sb.held - 1)];
    endfunction

    function automatic logic [PAGE_W-1:0] random_page();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return PAGE_W'($urandom);
        endcase
    endfunction

    function automatic logic [SLOT_W-1:0] random_slot();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return SLOT_W'($urandom);
        endcase
    endfunction

    // mostly fresh inserts and lookups aimed at held keys and their neighbors
    task automatic pick_random_request(output logic [REQ_W-1:0] req,
                                       output logic [KEY_IN_W-1:0] k,
                                       output logic [PAGE_W-1:0] pg,
                                       output logic [SLOT_W-1:0] sl);
        int unsigned roll;
        roll = $urandom_range(99);
        pg   = random_page();
        sl   = random_slot();
        k    = random_key();
        if (roll < 25) begin
            req = REQ_INSERT;
        end else if (roll < 32) begin
            req = REQ_INSERT;
            k   = held_key();
        end else if (roll < 52) begin
            req = REQ_EXACT;
            k   = held_key();
        end else if (roll < 62) begin
            req = REQ_EXACT;
        end else if (roll < 84) begin
            req = REQ_CHILD;
            k   = held_key() + KEY_IN_W'($urandom_range(2)) - 32'd1;
        end else if (roll < 95) begin
            req = REQ_CHILD;
        end else begin
            req = REQ_UNKNOWN;
        end
    endtask

    initial begin
        logic [REQ_W-1:0]    req;
        logic [KEY_IN_W-1:0] k;
        logic [PAGE_W-1:0]   pg;
        logic [SLOT_W-1:0]   sl;
        int unsigned         n;

        sb                = new();
        sender_idle_pct   = 18;
        receiver_idle_pct = 70;
        aresetn           = 1'b0;
        s_axis_tvalid     = 1'b0;
        s_axis_tuser      = REQ_INSERT;
        s_axis_tdata      = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // empty table, lookups and the unknown kind miss
        send_request(REQ_EXACT,   32'h0000_0000, 24'h00_0000, 16'h0000);
        send_request(REQ_CHILD,   32'hFFFF_FFFF, 24'h00_0000, 16'h0000);
        send_request(REQ_UNKNOWN, 32'h0000_0000, 24'hFF_FFFF, 16'hFFFF);
        // single entry, then insert at the end, at the front and a duplicate
        send_request(REQ_INSERT,  32'h8000_0000, 24'hFF_FFFF, 16'h0000);
        send_request(REQ_CHILD,   32'h0000_0000, 24'h00_0000, 16'h0000);
        send_request(REQ_INSERT,  32'hFFFF_FFFF, 24'h00_0000, 16'hFFFF);
        send_request(REQ_INSERT,  32'h0000_0001, 24'h12_3456, 16'h5A5A);
        send_request(REQ_INSERT,  32'h8000_0000, 24'h00_0000, 16'h0000);
        // exact hits and a miss between keys
        send_request(REQ_EXACT,   32'hFFFF_FFFF, 24'h00_0000, 16'h0000);
        send_request(REQ_EXACT,   32'h0000_0001, 24'h00_0000, 16'h0000);
        send_request(REQ_EXACT,   32'h0000_0002, 24'h00_0000, 16'h0000);
        // floor child at and around each boundary
        send_request(REQ_CHILD,   32'h0000_0000, 24'h00_0000, 16'h0000);
        send_request(REQ_CHILD,   32'h7FFF_FFFF, 24'h00_0000, 16'h0000);
        send_request(REQ_CHILD,   32'h8000_0000, 24'h00_0000, 16'h0000);
        send_request(REQ_CHILD,   32'hFFFF_FFFE, 24'h00_0000, 16'h0000);
        send_request(REQ_CHILD,   32'hFFFF_FFFF, 24'h00_0000, 16'h0000);
        // unknown kind on a filled table, then a middle insert
        send_request(REQ_UNKNOWN, 32'h8000_0000, 24'hFF_FFFF, 16'hFFFF);
        send_request(REQ_INSERT,  32'h7FFF_FFFF, 24'hAA_AAAA, 16'h5555);
        send_request(REQ_EXACT,   32'h7FFF_FFFF, 24'h00_0000, 16'h0000);

        // random part, the table fills and then stays full
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == RANDOM_REQUESTS / 3) begin
                sender_idle_pct   = 70;
                receiver_idle_pct = 18;
            end
            if (n == 2 * RANDOM_REQUESTS / 3) begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            pick_random_request(req, k, pg, sl);
            send_request(req, k, pg, sl);
        end
        s_axis_tvalid <= 1'b0;

        // drain, then give a stray result time to show up
        while (sb.awaiting.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("covered %0d requests: %0d inserted, %0d duplicates, %0d rejected as full",
                 sb.results_seen, sb.status_seen[STATUS_INSERTED],
                 sb.status_seen[STATUS_DUPLICATE], sb.status_seen[STATUS_FULL]);
        $display("lookups found %0d and missed %0d; table ended with %0d of %0d entries",
                 sb.status_seen[STATUS_FOUND], sb.status_seen[STATUS_MISS], sb.held, CAPACITY);
        if (sb.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ===== sorted_key_node_table_core.f =====
+incdir+sv
sv/sktbl_pkg.sv
sv/sktbl_ram.sv
sv/sktbl_cmp.sv
sv/sorted_key_node_table_core.sv
test/tb_sorted_key_node_table_core.sv
